/* design/tcwa_pkg.sv */
// ----------------------------------------------------------------------------
// tcwa_pkg: shared types and constants
// Defaults, controller states and the command/status bundles between the
// controller and the datapath of the three channel window average core.
// ----------------------------------------------------------------------------
package tcwa_pkg;

	localparam int unsigned WINDOW_DEPTH_DEFAULT = 8;
	localparam int unsigned SAMPLE_BITS_DEFAULT  = 10;
	localparam int unsigned AVG_BITS             = 8;
	localparam int unsigned AVG_SHIFT            = 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} tcwa_state_t;

	typedef struct packed {
		logic store;
		logic rd;
		logic div_start;
		logic div_step;
		logic out_load;
	} tcwa_cmd_t;

	typedef struct packed {
		logic rd_last;
		logic div_last;
		logic out_busy;
		logic hold;
	} tcwa_status_t;

endpackage

/* design/tcwa_sample_if.sv */
// ----------------------------------------------------------------------------
// tcwa_sample_if: sample request channel
// Valid/ready channel carrying one sample for each of the three channels.
// ----------------------------------------------------------------------------
interface tcwa_sample_if #(
	parameter int unsigned SAMPLE_BITS = tcwa_pkg::SAMPLE_BITS_DEFAULT
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample_in_voltage;
	logic [SAMPLE_BITS-1:0] sample_cap_voltage;
	logic [SAMPLE_BITS-1:0] sample_out_voltage;

	modport source (
		output valid, sample_in_voltage, sample_cap_voltage, sample_out_voltage,
		input  ready
	);
	modport sink (
		input  valid, sample_in_voltage, sample_cap_voltage, sample_out_voltage,
		output ready
	);
endinterface

/* design/tcwa_avg_if.sv */
// ----------------------------------------------------------------------------
// tcwa_avg_if: average request channel
// Valid/ready channel carrying the three 8-bit window averages.
// ----------------------------------------------------------------------------
interface tcwa_avg_if;
	logic                          valid;
	logic                          ready;
	logic [tcwa_pkg::AVG_BITS-1:0] avg_in_voltage;
	logic [tcwa_pkg::AVG_BITS-1:0] avg_cap_voltage;
	logic [tcwa_pkg::AVG_BITS-1:0] avg_out_voltage;

	modport source (
		output valid, avg_in_voltage, avg_cap_voltage, avg_out_voltage,
		input  ready
	);
	modport sink (
		input  valid, avg_in_voltage, avg_cap_voltage, avg_out_voltage,
		output ready
	);
endinterface

/* design/tcwa_divider.sv */
// ----------------------------------------------------------------------------
// tcwa_divider: restoring divider
// One quotient bit per step; the quotient replaces the dividend in place.
// ----------------------------------------------------------------------------
module tcwa_divider #(
	parameter int unsigned SUM_W = 13,
	parameter int unsigned CNT_W = 4
) (
	input  logic             clk,
	input  logic             start,
	input  logic             step,
	input  logic [SUM_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic [SUM_W-1:0] quotient
);
	logic [CNT_W-1:0] rem_q;
	logic [SUM_W-1:0] quo_q;
	logic [CNT_W-1:0] div_q;
	logic [CNT_W+1:0] diff;

	assign diff = {1'b0, rem_q, quo_q[SUM_W-1]} - {2'b00, div_q};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (step) begin
			if (!diff[CNT_W+1]) begin
				rem_q <= diff[CNT_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[CNT_W-2:0], quo_q[SUM_W-1]};
				quo_q <= {quo_q[SUM_W-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
endmodule

/* design/tcwa_datapath.sv */
// ----------------------------------------------------------------------------
// tcwa_datapath: windows, sums, dividers and output register
// Three window memories share one write slot and one read index; the
// registered read data feed three accumulators and then three dividers.
// ----------------------------------------------------------------------------
module tcwa_datapath #(
	parameter int unsigned WINDOW_DEPTH = tcwa_pkg::WINDOW_DEPTH_DEFAULT,
	parameter int unsigned SAMPLE_BITS  = tcwa_pkg::SAMPLE_BITS_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tcwa_pkg::tcwa_cmd_t           cmd,
	output tcwa_pkg::tcwa_status_t        status,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,
	input  logic [SAMPLE_BITS-1:0]        sample_in_voltage,
	input  logic [SAMPLE_BITS-1:0]        sample_cap_voltage,
	input  logic [SAMPLE_BITS-1:0]        sample_out_voltage,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [tcwa_pkg::AVG_BITS-1:0] avg_in_voltage,
	output logic [tcwa_pkg::AVG_BITS-1:0] avg_cap_voltage,
	output logic [tcwa_pkg::AVG_BITS-1:0] avg_out_voltage
);
	import tcwa_pkg::*;

	localparam int unsigned IDX_W  = $clog2(WINDOW_DEPTH);
	localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
	localparam int unsigned SUM_W  = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
	localparam int unsigned STEP_W = $clog2(SUM_W);

	logic [SAMPLE_BITS-1:0] mem_in_q  [WINDOW_DEPTH];
	logic [SAMPLE_BITS-1:0] mem_cap_q [WINDOW_DEPTH];
	logic [SAMPLE_BITS-1:0] mem_out_q [WINDOW_DEPTH];

	logic [IDX_W-1:0]       slot_q;
	logic [CNT_W-1:0]       count_q;
	logic [IDX_W-1:0]       rd_idx_q;
	logic                   rd_vld_s1;
	logic [SAMPLE_BITS-1:0] rd_in_s1;
	logic [SAMPLE_BITS-1:0] rd_cap_s1;
	logic [SAMPLE_BITS-1:0] rd_out_s1;
	logic [SUM_W-1:0]       acc_in_q;
	logic [SUM_W-1:0]       acc_cap_q;
	logic [SUM_W-1:0]       acc_out_q;
	logic [STEP_W-1:0]      step_q;
	logic                   hold_q;
	logic                   out_valid_q;
	logic [SUM_W-1:0]       quo_in;
	logic [SUM_W-1:0]       quo_cap;
	logic [SUM_W-1:0]       quo_out;
	logic [SUM_W-1:0]       sh_in;
	logic [SUM_W-1:0]       sh_cap;
	logic [SUM_W-1:0]       sh_out;

	// window memories
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			mem_in_q[slot_q]  <= sample_in_voltage;
			mem_cap_q[slot_q] <= sample_cap_voltage;
			mem_out_q[slot_q] <= sample_out_voltage;
		end
		if (cmd.rd) begin
			rd_in_s1  <= mem_in_q[rd_idx_q];
			rd_cap_s1 <= mem_cap_q[rd_idx_q];
			rd_out_s1 <= mem_out_q[rd_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= '0;
			count_q     <= '0;
			rd_idx_q    <= '0;
			rd_vld_s1   <= 1'b0;
			step_q      <= '0;
			hold_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd;
			if (cfg_we) begin
				hold_q <= cfg_wdata;
			end
			if (cmd.store) begin
				rd_idx_q <= '0;
				if (slot_q == IDX_W'(WINDOW_DEPTH - 1)) begin
					slot_q <= '0;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
				if (count_q != CNT_W'(WINDOW_DEPTH)) begin
					count_q <= count_q + 1'b1;
				end
			end else if (cmd.rd) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (cmd.div_start) begin
				step_q <= '0;
			end else if (cmd.div_step) begin
				step_q <= step_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// sums
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			acc_in_q  <= '0;
			acc_cap_q <= '0;
			acc_out_q <= '0;
		end else if (rd_vld_s1) begin
			acc_in_q  <= acc_in_q  + SUM_W'(rd_in_s1);
			acc_cap_q <= acc_cap_q + SUM_W'(rd_cap_s1);
			acc_out_q <= acc_out_q + SUM_W'(rd_out_s1);
		end
	end

	tcwa_divider #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div_in (
		.clk(clk), .start(cmd.div_start), .step(cmd.div_step),
		.dividend(acc_in_q), .divisor(count_q), .quotient(quo_in)
	);
	tcwa_divider #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div_cap (
		.clk(clk), .start(cmd.div_start), .step(cmd.div_step),
		.dividend(acc_cap_q), .divisor(count_q), .quotient(quo_cap)
	);
	tcwa_divider #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div_out (
		.clk(clk), .start(cmd.div_start), .step(cmd.div_step),
		.dividend(acc_out_q), .divisor(count_q), .quotient(quo_out)
	);

	assign sh_in  = quo_in  >> AVG_SHIFT;
	assign sh_cap = quo_cap >> AVG_SHIFT;
	assign sh_out = quo_out >> AVG_SHIFT;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			avg_in_voltage  <= AVG_BITS'(sh_in);
			avg_cap_voltage <= AVG_BITS'(sh_cap);
			avg_out_voltage <= AVG_BITS'(sh_out);
		end
	end

	assign out_valid       = out_valid_q;
	assign status.rd_last  = (CNT_W'(rd_idx_q) + 1'b1) == count_q;
	assign status.div_last = step_q == STEP_W'(SUM_W - 1);
	assign status.out_busy = out_valid_q && !out_ready;
	assign status.hold     = hold_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(WINDOW_DEPTH))
		else $error("valid count above window depth");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> count_q != '0)
		else $error("divide started with empty window");
	a_rd_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> CNT_W'(rd_idx_q) < count_q)
		else $error("read beyond written entries");
	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("pending average overwritten");
`endif
endmodule

/* design/tcwa_ctrl.sv */
// ----------------------------------------------------------------------------
// tcwa_ctrl: sequencing state machine
// Accepts a sample request, sweeps the windows, runs the dividers and,
// unless hold is set, hands the averages to the output register.
// ----------------------------------------------------------------------------
module tcwa_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  tcwa_pkg::tcwa_status_t status,
	output tcwa_pkg::tcwa_cmd_t    cmd
);
	import tcwa_pkg::*;

	tcwa_state_t state_q;
	tcwa_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.store = 1'b1;
					state_d   = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd = 1'b1;
				if (status.rd_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (status.hold) begin
					state_d = ST_IDLE;
				end else if (!status.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule

/* design/three_channel_window_average_core.sv */
// ----------------------------------------------------------------------------
// three_channel_window_average_core: windowed average of three channels
// Stores each sample set in three circular windows and publishes the
// truncated window averages, shifted right two bits, unless held.
// ----------------------------------------------------------------------------
//  port       dir  request
//  samples    in   sample_in/cap/out_voltage
//  averages   out  avg_in/cap/out_voltage
//  cfg_we     in   hold_results write (cfg_wdata)
//
//  Each item sweeps the n valid entries (n at most WINDOW_DEPTH), one
//  memory read a cycle, then runs the one-bit-a-step divider over the
//  SUM_W = SAMPLE_BITS + log2(WINDOW_DEPTH) bit sums (13 at defaults).
//  Reset clears slot, count, hold and the output valid; window contents
//  are not cleared. A pending average does not block the next sample; a
//  finished one waits only while the previous is untaken.
// ----------------------------------------------------------------------------
module three_channel_window_average_core #(
	parameter int unsigned WINDOW_DEPTH = tcwa_pkg::WINDOW_DEPTH_DEFAULT,
	parameter int unsigned SAMPLE_BITS  = tcwa_pkg::SAMPLE_BITS_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_wdata,
	tcwa_sample_if.sink  samples,
	tcwa_avg_if.source   averages
);
	import tcwa_pkg::*;

	tcwa_cmd_t    cmd;
	tcwa_status_t status;

	tcwa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (samples.ready),
		.status   (status),
		.cmd      (cmd)
	);

	tcwa_datapath #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.SAMPLE_BITS  (SAMPLE_BITS)
	) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.status             (status),
		.cfg_we             (cfg_we),
		.cfg_wdata          (cfg_wdata),
		.sample_in_voltage  (samples.sample_in_voltage),
		.sample_cap_voltage (samples.sample_cap_voltage),
		.sample_out_voltage (samples.sample_out_voltage),
		.out_ready          (averages.ready),
		.out_valid          (averages.valid),
		.avg_in_voltage     (averages.avg_in_voltage),
		.avg_cap_voltage    (averages.avg_cap_voltage),
		.avg_out_voltage    (averages.avg_out_voltage)
	);
endmodule

/* sim/tcwa_avg_checker.sv */
// ----------------------------------------------------------------------------
// tcwa_avg_checker: scoreboard for the three channel window average core
// Watches the sample and average requests and the hold register writes. It
// keeps its own copy of the three windows, the write slot and the fill count,
// predicts averages for each sample request accepted with hold clear and compares
// every accepted average request, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module tcwa_avg_checker (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic                                    cfg_wdata,
	input  logic                                    sample_valid,
	input  logic                                    sample_ready,
	input  logic [tcwa_pkg::SAMPLE_BITS_DEFAULT-1:0] sample_in_voltage,
	input  logic [tcwa_pkg::SAMPLE_BITS_DEFAULT-1:0] sample_cap_voltage,
	input  logic [tcwa_pkg::SAMPLE_BITS_DEFAULT-1:0] sample_out_voltage,
	input  logic                                    avg_valid,
	input  logic                                    avg_ready,
	input  logic [tcwa_pkg::AVG_BITS-1:0]            avg_in_voltage,
	input  logic [tcwa_pkg::AVG_BITS-1:0]            avg_cap_voltage,
	input  logic [tcwa_pkg::AVG_BITS-1:0]            avg_out_voltage,
	output int                                      error_count,
	output int                                      pending_count,
	output int                                      checked_count,
	output int                                      held_count
);
	import tcwa_pkg::*;

	localparam int unsigned DEPTH        = WINDOW_DEPTH_DEFAULT;
	localparam int unsigned SB           = SAMPLE_BITS_DEFAULT;
	localparam int unsigned AB           = AVG_BITS;
	localparam int unsigned SUM_W        = SB + $clog2(DEPTH);
	localparam int unsigned NUM_CH       = 3;
	localparam int          REPORT_LIMIT = 10;

	typedef enum int {
		CH_IN,
		CH_CAP,
		CH_OUT
	} channel_t;

	typedef struct packed {
		logic [AB-1:0] in_v;
		logic [AB-1:0] cap_v;
		logic [AB-1:0] out_v;
	} avg_set_t;

	avg_set_t                   avg_expected_q[$];
	logic [SB-1:0]              window_mem [NUM_CH][DEPTH];
	bit   [$clog2(DEPTH)-1:0]   write_slot;
	bit   [$clog2(DEPTH):0]     fill_count;
	bit                         hold_copy;

	function automatic logic [AB-1:0] window_mean(input channel_t ch);
		logic [SUM_W-1:0] total;
		int unsigned      k;
		total = '0;
		for (k = 0; k < fill_count; k++)
			total += window_mem[ch][k];
		return AB'((32'(total) / fill_count) >> AVG_SHIFT);
	endfunction

	task automatic report(input string what, input string exp_txt, input avg_set_t got);
		error_count++;
		if (error_count <= REPORT_LIMIT) begin
			$display("ERROR at %0t: %s; expected %s, got in=%0d cap=%0d out=%0d",
				$time, what, exp_txt, got.in_v, got.cap_v, got.out_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		avg_set_t got;
		avg_set_t want;
		string    bad;
		if (!arst_n) begin
			avg_expected_q.delete();
			write_slot    = '0;
			fill_count    = '0;
			hold_copy     = 1'b0;
			error_count   = 0;
			pending_count = 0;
			checked_count = 0;
			held_count    = 0;
		end else begin
			if (cfg_we)
				hold_copy = cfg_wdata;

			// older average request first: it never belongs to a sample taken this edge
			if (avg_valid && avg_ready) begin
				got = '{avg_in_voltage, avg_cap_voltage, avg_out_voltage};
				checked_count++;
				if (avg_expected_q.size() == 0) begin
					report("average request with none pending", "nothing", got);
				end else begin
					want = avg_expected_q.pop_front();
					bad  = "";
					if (got.in_v !== want.in_v)
						bad = {bad, " in"};
					if (got.cap_v !== want.cap_v)
						bad = {bad, " cap"};
					if (got.out_v !== want.out_v)
						bad = {bad, " out"};
					if (bad != "") begin
						report({"mismatch on", bad},
							$sformatf("in=%0d cap=%0d out=%0d", want.in_v, want.cap_v, want.out_v),
							got);
					end
				end
			end

			if (sample_valid && sample_ready) begin
				window_mem[CH_IN][write_slot]  = sample_in_voltage;
				window_mem[CH_CAP][write_slot] = sample_cap_voltage;
				window_mem[CH_OUT][write_slot] = sample_out_voltage;
				write_slot = (write_slot == DEPTH - 1) ? '0 : write_slot + 1'b1;
				if (fill_count < DEPTH)
					fill_count++;
				if (hold_copy) begin
					held_count++;
				end else begin
					want = '{window_mean(CH_IN), window_mean(CH_CAP), window_mean(CH_OUT)};
					avg_expected_q.push_back(want);
				end
			end

			pending_count = avg_expected_q.size();
		end
	end

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench for three_channel_window_average_core
// Drives sample requests and the hold register, throttles the average
// channel, and reports the verdict from the checker's error and pending
// counts. A short directed part covers extremes, the window ramp and wrap
// and the hold mode; random segments follow with hold toggled, random
// idling and one long output holdoff that backs the core up into its input.
// ----------------------------------------------------------------------------
module tb_top;
	import tcwa_pkg::*;

	localparam int unsigned SB             = SAMPLE_BITS_DEFAULT;
	localparam logic [SB-1:0] SMAX         = '1;
	localparam int          NUM_SEGS       = 8;
	localparam int          SEG_ITEMS      = 125;
	localparam int          DRAIN_CYCLES   = 64;
	localparam int          HOLDOFF_CYCLES = 400;
	localparam int          CYCLE_LIMIT    = 800000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	tcwa_sample_if sample_bus ();
	tcwa_avg_if    avg_bus ();

	int err_count;
	int pending_count;
	int checked_count;
	int held_count;
	int cycle_count;
	int items_sent;
	int hold_writes;
	int holdoffs;
	int holdoff_reqs;
	bit sender_quiet;
	bit recv_quiet;

	three_channel_window_average_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.samples   (sample_bus),
		.averages  (avg_bus)
	);

	tcwa_avg_checker checker_i (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_wdata          (cfg_wdata),
		.sample_valid       (sample_bus.valid),
		.sample_ready       (sample_bus.ready),
		.sample_in_voltage  (sample_bus.sample_in_voltage),
		.sample_cap_voltage (sample_bus.sample_cap_voltage),
		.sample_out_voltage (sample_bus.sample_out_voltage),
		.avg_valid          (avg_bus.valid),
		.avg_ready          (avg_bus.ready),
		.avg_in_voltage     (avg_bus.avg_in_voltage),
		.avg_cap_voltage    (avg_bus.avg_cap_voltage),
		.avg_out_voltage    (avg_bus.avg_out_voltage),
		.error_count        (err_count),
		.pending_count      (pending_count),
		.checked_count      (checked_count),
		.held_count         (held_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timeout after %0d cycles, %0d averages still pending", cycle_count,
			pending_count);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// mostly short gaps, a few long ones
	function automatic int unsigned pick_gap(input bit quiet);
		int unsigned r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [SB-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0: begin
				return '0;
			end
			1: begin
				return SMAX;
			end
			2: begin
				return SB'($urandom_range(0, 15));
			end
			3: begin
				return SMAX - SB'($urandom_range(0, 15));
			end
			default: begin
				return SB'($urandom);
			end
		endcase
	endfunction

	task automatic send_sample(input logic [SB-1:0] vin, input logic [SB-1:0] vcap,
			input logic [SB-1:0] vout);
		int unsigned gap;
		gap = pick_gap(sender_quiet);
		repeat (gap) begin
			@(negedge clk);
			sample_bus.valid <= 1'b0;
		end
		@(negedge clk);
		sample_bus.valid              <= 1'b1;
		sample_bus.sample_in_voltage  <= vin;
		sample_bus.sample_cap_voltage <= vcap;
		sample_bus.sample_out_voltage <= vout;
		@(posedge clk);
		while (!sample_bus.ready)
			@(posedge clk);
		items_sent++;
	endtask

	// idle point: no sample offered, all averages in, core drained
	task automatic settle();
		@(negedge clk);
		sample_bus.valid <= 1'b0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
	endtask

	task automatic write_hold(input logic value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		hold_writes++;
	endtask

	initial begin : receiver
		int unsigned idle_left;
		int unsigned stall_left;
		idle_left     = 0;
		stall_left    = 0;
		avg_bus.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (stall_left != 0) begin
				avg_bus.ready <= 1'b0;
				stall_left--;
			end else if (holdoff_reqs != holdoffs) begin
				holdoffs++;
				stall_left  = HOLDOFF_CYCLES - 1;
				avg_bus.ready <= 1'b0;
			end else if (idle_left != 0) begin
				avg_bus.ready <= 1'b0;
				idle_left--;
			end else begin
				avg_bus.ready <= 1'b1;
				if (!recv_quiet && $urandom_range(0, 2) == 0)
					idle_left = pick_gap(1'b0);
			end
		end
	end

	initial begin : stimulus
		int seg;
		int k;
		arst_n                        = 1'b0;
		cfg_we                        = 1'b0;
		cfg_wdata                     = 1'b0;
		sample_bus.valid              = 1'b0;
		sample_bus.sample_in_voltage  = '0;
		sample_bus.sample_cap_voltage = '0;
		sample_bus.sample_out_voltage = '0;
		sender_quiet                  = 1'b0;
		recv_quiet                    = 1'b0;
		repeat (5)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// window ramp from one entry, extremes, bit patterns, then wrap
		write_hold(1'b0);
		send_sample(SMAX, SMAX, SMAX);
		send_sample('0, '0, '0);
		send_sample(SMAX, '0, SB'(512));
		send_sample('0, SMAX, SB'(1));
		send_sample(SB'(10'h155), SB'(10'h2AA), SMAX);
		send_sample(SB'(10'h2AA), SB'(10'h155), '0);
		send_sample(SB'(1), SB'(2), SB'(3));
		send_sample(SMAX, SMAX, SMAX);
		send_sample(SMAX, SMAX, SMAX);
		send_sample('0, '0, '0);

		// held: windows keep filling, no averages
		settle();
		write_hold(1'b1);
		send_sample(SMAX, '0, SMAX);
		send_sample(SMAX, '0, SMAX);
		send_sample('0, SMAX, '0);
		send_sample(SMAX, SMAX, '0);

		settle();
		write_hold(1'b0);
		send_sample('0, '0, SMAX);
		send_sample(SMAX, SMAX, SMAX);
		send_sample(SB'(3), SMAX, SB'(10'h200));

		for (seg = 0; seg < NUM_SEGS; seg++) begin
			settle();
			write_hold(seg == 2 || seg == 5);
			sender_quiet = (seg == 0 || seg == 3) ? 1'b1 : ($urandom_range(0, 3) == 0);
			recv_quiet   = (seg == 0) ? 1'b1 : ($urandom_range(0, 3) == 0);
			for (k = 0; k < SEG_ITEMS; k++) begin
				if (seg == 3 && k == 20)
					holdoff_reqs++;
				send_sample(rand_sample(), rand_sample(), rand_sample());
			end
		end

		settle();
		$display("Run covered %0d sample requests (%0d held back) and %0d average requests,",
			items_sent, held_count, checked_count);
		$display("with %0d hold register writes and %0d long output holdoffs.",
			hold_writes, holdoffs);
		if (err_count == 0 && pending_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d errors", err_count);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

/* filelist.f */
design/tcwa_pkg.sv
design/tcwa_sample_if.sv
design/tcwa_avg_if.sv
design/tcwa_divider.sv
design/tcwa_datapath.sv
design/tcwa_ctrl.sv
design/three_channel_window_average_core.sv
sim/tcwa_avg_checker.sv
sim/tb_top.sv
